// File: sv/range_set_union_difference_assert.svh
// assertion macros for the range set block
`ifndef RANGE_SET_UNION_DIFFERENCE_ASSERT_SVH
`define RANGE_SET_UNION_DIFFERENCE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RSUD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RSUD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rsud_pkg.sv
// types and codes shared by the range set block
package rsud_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] range_low;
        logic [15:0] range_high;
    } t_req;

    typedef struct packed {
        logic [15:0] entry_low;
        logic [15:0] entry_high;
        logic        set_empty;
        logic [1:0]  status;
        logic        last_of_run;
    } t_rsp;

    typedef struct packed {
        logic rotate;
        logic commit;
        logic push_a;
        logic push_b;
    } t_cell_ctl;

endpackage

// File: sv/rsud_cell.sv
// one table cell with its scratch entry, rotating to its neighbor
module rsud_cell #(
    parameter int VB  = 16,
    parameter int CW  = 6,
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  rsud_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]      i_wp,
    input  logic [VB-1:0]      i_a_lo,
    input  logic [VB-1:0]      i_a_hi,
    input  logic [VB-1:0]      i_b_lo,
    input  logic [VB-1:0]      i_b_hi,
    input  logic [VB-1:0]      i_next_lo,
    input  logic [VB-1:0]      i_next_hi,
    output logic [VB-1:0]      o_lo,
    output logic [VB-1:0]      o_hi
);
    import rsud_pkg::*;

    logic [VB-1:0] r_lo, r_hi;
    logic [VB-1:0] r_s_lo, r_s_hi;
    logic          hit_a, hit_b;

    assign hit_a = i_ctl.push_a && (i_wp == CW'(IDX));
    assign hit_b = i_ctl.push_b && (CW'(i_wp + CW'(1)) == CW'(IDX));

    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate) begin
            r_lo <= i_next_lo;
            r_hi <= i_next_hi;
        end else if (i_ctl.commit) begin
            r_lo <= r_s_lo;
            r_hi <= r_s_hi;
        end
        if (hit_a) begin
            r_s_lo <= i_a_lo;
            r_s_hi <= i_a_hi;
        end else if (hit_b) begin
            r_s_lo <= i_b_lo;
            r_s_hi <= i_b_hi;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

// File: sv/range_set_union_difference.sv
// range set top level: cell chain, walk control and result register
//
//  channel   | signals                      | handshake
//  request   | start, i_req                 | taken when start and not busy
//  result    | o_rsp_strobe, o_rsp          | each result strobed, no stall
//
// every request takes a full rotation of the cell chain (S_WALK), then a step
// to close an add (S_FIN) and one to commit and answer (S_DONE).
// dump results come out during the rotation, one per stored entry per cycle;
// an empty set answers at the end. reset empties the table at once; no clearing pass.
// results cannot be held off; busy stays high until the request is done.
module range_set_union_difference #(
    parameter int MAX_INTERVALS = 32,
    parameter int VALUE_BITS    = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  rsud_pkg::t_req i_req,
    output logic           busy,
    output logic           o_rsp_strobe,
    output rsud_pkg::t_rsp o_rsp
);
    import rsud_pkg::*;

    localparam int M  = MAX_INTERVALS;
    localparam int VB = VALUE_BITS;
    localparam int CW = $clog2(M + 3);
    localparam int KW = $clog2(M);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN, S_DONE} t_state;

    t_state        r_state;
    logic [1:0]    r_op;
    logic [VB-1:0] r_lo, r_hi, r_nl, r_nh;
    logic [VB-1:0] n_nl, n_nh;
    logic          r_placed, n_placed;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_wp, r_count;
    t_rsp          r_rsp;
    logic          r_strobe;

    logic [VB-1:0] c_lo [M];
    logic [VB-1:0] c_hi [M];
    logic [VB-1:0] a_lo, a_hi, b_lo, b_hi;
    logic [VB-1:0] el, eh;
    logic          active, inverted, do_commit;
    t_cell_ctl     ctl;
    logic [CW-1:0] wp_next;

    assign el       = c_lo[0];
    assign eh       = c_hi[0];
    assign active   = (r_state == S_WALK) && (CW'(r_k) < r_count);
    assign inverted = r_lo > r_hi;
    assign do_commit = (r_state == S_DONE) && (r_op == OP_ADD || r_op == OP_REMOVE)
                       && !inverted && (r_wp <= CW'(M));
    assign wp_next  = CW'(r_wp + CW'(ctl.push_a) + CW'(ctl.push_b));

    always_comb begin
        ctl.rotate = (r_state == S_WALK);
        ctl.commit = do_commit;
        ctl.push_a = 1'b0;
        ctl.push_b = 1'b0;
        a_lo = el;
        a_hi = eh;
        b_lo = el;
        b_hi = eh;
        n_nl = r_nl;
        n_nh = r_nh;
        n_placed = r_placed;
        if (active && r_op == OP_ADD) begin
            if (({1'b0, eh} + {{VB{1'b0}}, 1'b1}) < {1'b0, r_nl}) begin
                ctl.push_a = 1'b1;
            end else if ({1'b0, el} > ({1'b0, r_nh} + {{VB{1'b0}}, 1'b1})) begin
                ctl.push_a = 1'b1;
                if (!r_placed) begin
                    a_lo = r_nl;
                    a_hi = r_nh;
                    ctl.push_b = 1'b1;
                    n_placed = 1'b1;
                end
            end else begin
                if (el < r_nl) n_nl = el;
                if (eh > r_nh) n_nh = eh;
            end
        end else if (active && r_op == OP_REMOVE) begin
            if (el > r_hi || eh < r_lo) begin
                ctl.push_a = 1'b1;
            end else if (el < r_lo && eh > r_hi) begin
                ctl.push_a = 1'b1;
                a_hi = VB'(r_lo - VB'(1));
                ctl.push_b = 1'b1;
                b_lo = VB'(r_hi + VB'(1));
            end else if (el < r_lo) begin
                ctl.push_a = 1'b1;
                a_hi = VB'(r_lo - VB'(1));
            end else if (eh > r_hi) begin
                ctl.push_a = 1'b1;
                a_lo = VB'(r_hi + VB'(1));
            end
        end else if (r_state == S_FIN && r_op == OP_ADD && !r_placed) begin
            ctl.push_a = 1'b1;
            a_lo = r_nl;
            a_hi = r_nh;
        end
    end

    for (genvar g = 0; g < M; g++) begin : g_cell
        rsud_cell #(
            .VB (VB),
            .CW (CW),
            .IDX(g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_wp     (r_wp),
            .i_a_lo   (a_lo),
            .i_a_hi   (a_hi),
            .i_b_lo   (b_lo),
            .i_b_hi   (b_hi),
            .i_next_lo(c_lo[(g + 1) % M]),
            .i_next_hi(c_hi[(g + 1) % M]),
            .o_lo     (c_lo[g]),
            .o_hi     (c_hi[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op     <= i_req.opcode;
                        r_lo     <= VB'(i_req.range_low);
                        r_hi     <= VB'(i_req.range_high);
                        r_nl     <= VB'(i_req.range_low);
                        r_nh     <= VB'(i_req.range_high);
                        r_placed <= 1'b0;
                        r_k      <= '0;
                        r_wp     <= '0;
                        r_state  <= S_WALK;
                    end
                end
                S_WALK: begin
                    r_nl     <= n_nl;
                    r_nh     <= n_nh;
                    r_placed <= n_placed;
                    r_wp     <= wp_next;
                    if (r_op == OP_DUMP && active) begin
                        r_strobe          <= 1'b1;
                        r_rsp.entry_low   <= 16'(el);
                        r_rsp.entry_high  <= 16'(eh);
                        r_rsp.set_empty   <= 1'b0;
                        r_rsp.status      <= ST_OK;
                        r_rsp.last_of_run <= (CW'(CW'(r_k) + CW'(1)) == r_count);
                    end
                    r_k <= KW'(r_k + KW'(1));
                    if (r_k == KW'(M - 1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_wp    <= wp_next;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_rsp.entry_low   <= '0;
                    r_rsp.entry_high  <= '0;
                    r_rsp.last_of_run <= 1'b1;
                    r_rsp.set_empty   <= 1'b0;
                    r_rsp.status      <= ST_OK;
                    if (r_op == OP_DUMP) begin
                        r_strobe        <= (r_count == '0);
                        r_rsp.set_empty <= 1'b1;
                    end else begin
                        r_strobe <= 1'b1;
                        if (r_op == OP_UNUSED || inverted) begin
                            r_rsp.status <= ST_INVALID;
                        end else if (r_wp > CW'(M)) begin
                            r_rsp.status <= ST_FULL;
                        end
                    end
                    if (do_commit) r_count <= r_wp;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_rsp_strobe = r_strobe;
    assign o_rsp        = r_rsp;

endmodule

// File: sv/rsud_checker.sv
// port-level checks for the range set block, bound to the top level
`include "range_set_union_difference_assert.svh"

module rsud_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_rsp_strobe,
    input rsud_pkg::t_rsp o_rsp
);
    import rsud_pkg::*;

    `RSUD_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "request taken but not busy")
    `RSUD_ASSERT_NEXT(a_gap_after_last, o_rsp_strobe && o_rsp.last_of_run, !o_rsp_strobe,
        "result right after last of run")
    `RSUD_ASSERT_NOW(a_empty_is_last, o_rsp_strobe && o_rsp.set_empty,
        o_rsp.last_of_run && o_rsp.entry_low == 16'd0 && o_rsp.entry_high == 16'd0,
        "empty dump result malformed")
    `RSUD_ASSERT_NOW(a_status_clean, o_rsp_strobe && o_rsp.status != ST_OK,
        o_rsp.last_of_run && !o_rsp.set_empty && o_rsp.entry_low == 16'd0,
        "error status result malformed")

endmodule

bind range_set_union_difference rsud_checker u_rsud_checker (.*);

// File: bench/range_set_checker.sv
// checker for the range set block: predicts results and compares them
module range_set_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           busy,
    input  rsud_pkg::t_req i_req,
    input  logic           o_rsp_strobe,
    input  rsud_pkg::t_rsp o_rsp,
    output int             fail_count,
    output int             pending_count,
    output int             result_total
);
    import rsud_pkg::*;

    localparam int CAP = 32;

    logic [15:0] tbl_lo [CAP];
    logic [15:0] tbl_hi [CAP];
    int          tbl_n;
    t_rsp        expected_rsp_q[$];

    task automatic enqueue_rsp(input t_rsp r);
        expected_rsp_q = {expected_rsp_q, r};
    endtask

    task automatic push_status(input logic [1:0] st);
        t_rsp r;
        r = '0;
        r.status = st;
        r.last_of_run = 1'b1;
        enqueue_rsp(r);
    endtask

    task automatic apply_request(input t_req q);
        logic [16:0] new_lo, new_hi;
        logic [16:0] el, eh;
        logic [15:0] s_lo [CAP+2];
        logic [15:0] s_hi [CAP+2];
        int          n;
        bit          placed;
        t_rsp        r;
        n = 0;
        placed = 0;
        if (q.opcode == OP_DUMP) begin
            if (tbl_n == 0) begin
                r = '0;
                r.set_empty = 1'b1;
                r.last_of_run = 1'b1;
                enqueue_rsp(r);
            end else begin
                for (int i = 0; i < tbl_n; i++) begin
                    r = '0;
                    r.entry_low = tbl_lo[i];
                    r.entry_high = tbl_hi[i];
                    r.last_of_run = (i == tbl_n - 1);
                    enqueue_rsp(r);
                end
            end
            return;
        end
        if (q.opcode == OP_UNUSED || q.range_low > q.range_high) begin
            push_status(ST_INVALID);
            return;
        end
        if (q.opcode == OP_ADD) begin
            new_lo = q.range_low;
            new_hi = q.range_high;
            for (int i = 0; i < tbl_n; i++) begin
                el = tbl_lo[i];
                eh = tbl_hi[i];
                if (eh + 1 < new_lo) begin
                    s_lo[n] = tbl_lo[i]; s_hi[n] = tbl_hi[i]; n++;
                end else if (el > new_hi + 1) begin
                    if (!placed) begin
                        s_lo[n] = new_lo[15:0]; s_hi[n] = new_hi[15:0]; n++;
                        placed = 1;
                    end
                    s_lo[n] = tbl_lo[i]; s_hi[n] = tbl_hi[i]; n++;
                end else begin
                    if (el < new_lo) new_lo = el;
                    if (eh > new_hi) new_hi = eh;
                end
            end
            if (!placed) begin
                s_lo[n] = new_lo[15:0]; s_hi[n] = new_hi[15:0]; n++;
            end
        end else begin
            for (int i = 0; i < tbl_n; i++) begin
                if (tbl_lo[i] > q.range_high || tbl_hi[i] < q.range_low) begin
                    s_lo[n] = tbl_lo[i]; s_hi[n] = tbl_hi[i]; n++;
                end else begin
                    if (tbl_lo[i] < q.range_low) begin
                        s_lo[n] = tbl_lo[i]; s_hi[n] = q.range_low - 16'd1; n++;
                    end
                    if (tbl_hi[i] > q.range_high) begin
                        s_lo[n] = q.range_high + 16'd1; s_hi[n] = tbl_hi[i]; n++;
                    end
                end
            end
        end
        if (n > CAP) begin
            push_status(ST_FULL);
        end else begin
            for (int i = 0; i < n; i++) begin
                tbl_lo[i] = s_lo[i];
                tbl_hi[i] = s_hi[i];
            end
            tbl_n = n;
            push_status(ST_OK);
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            tbl_n = 0;
            fail_count = 0;
            result_total = 0;
            expected_rsp_q.delete();
        end else begin
            if (o_rsp_strobe) begin
                result_total++;
                if (expected_rsp_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", o_rsp);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (o_rsp !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: lo %h/%h hi %h/%h empty %b/%b st %0d/%0d last %b/%b",
                                     want.entry_low, o_rsp.entry_low,
                                     want.entry_high, o_rsp.entry_high,
                                     want.set_empty, o_rsp.set_empty,
                                     want.status, o_rsp.status,
                                     want.last_of_run, o_rsp.last_of_run);
                    end
                end
            end
            if (start && !busy)
                apply_request(i_req);
        end
        pending_count = expected_rsp_q.size();
    end
endmodule

// File: bench/testbench.sv
// top of the range set testbench: stimulus, timeout and verdict
module testbench;
    import rsud_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_rsp_strobe;
    t_rsp o_rsp;
    int   fail_count, pending_count, result_total;
    int   cycle_count;
    int   sent;

    range_set_union_difference u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_req(i_req),
        .busy(busy), .o_rsp_strobe(o_rsp_strobe), .o_rsp(o_rsp)
    );

    range_set_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_rsp_strobe(o_rsp_strobe), .o_rsp(o_rsp),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_total(result_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("range_set_union_difference regression: fail");
            $finish;
        end
    end

    // hold start until taken, then drop it or keep it for the next request
    task automatic send_request(input logic [1:0] op, input logic [15:0] lo,
                                input logic [15:0] hi);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                          : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= '{opcode: op, range_low: lo, range_high: hi};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'($urandom_range(0, 300));
            3: return 16'($urandom_range(65235, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [1:0]  op;
        logic [15:0] lo, hi, tmp;
        sent = 0;
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty dump, remove on empty, extremes, merges, splits, invalid, full
        send_request(OP_DUMP, 16'h0, 16'h0);
        send_request(OP_REMOVE, 16'h0, 16'hffff);
        send_request(OP_ADD, 16'h0, 16'h0);
        send_request(OP_ADD, 16'hffff, 16'hffff);
        send_request(OP_ADD, 16'h0002, 16'h0004);
        send_request(OP_ADD, 16'h0001, 16'h0001);
        send_request(OP_DUMP, 16'hffff, 16'h0);
        send_request(OP_ADD, 16'h0010, 16'h0003);
        send_request(OP_UNUSED, 16'h0001, 16'h0002);
        send_request(OP_REMOVE, 16'h0002, 16'h0002);
        send_request(OP_REMOVE, 16'h0005, 16'h0001);
        send_request(OP_DUMP, 16'h0, 16'h0);
        for (int i = 0; i < 33; i++)
            send_request(OP_ADD, 16'(i * 4 + 100), 16'(i * 4 + 101));
        send_request(OP_REMOVE, 16'd104, 16'd104);
        send_request(OP_DUMP, 16'h0, 16'h0);
        send_request(OP_REMOVE, 16'h0000, 16'hffff);
        send_request(OP_DUMP, 16'h0, 16'h0);

        // random: mostly well-formed ranges, some inverted and unused ops
        for (int i = 0; i < 370; i++) begin
            case ($urandom_range(0, 19))
                0:                op = OP_UNUSED;
                1, 2, 3:          op = OP_DUMP;
                4, 5, 6, 7, 8, 9: op = OP_REMOVE;
                default:          op = OP_ADD;
            endcase
            lo = pick_value();
            if ($urandom_range(0, 2) == 0)
                hi = lo + 16'($urandom_range(0, 20));
            else
                hi = pick_value();
            if (hi < lo && $urandom_range(0, 9) != 0) begin
                tmp = lo; lo = hi; hi = tmp;
            end
            if (op == OP_ADD && $urandom_range(0, 1) == 0 && hi - lo > 40)
                hi = lo + 16'($urandom_range(0, 40));
            send_request(op, lo, hi);
            if ($urandom_range(0, 60) == 0)
                send_request(OP_REMOVE, 16'h0000, 16'hffff);
        end
        start <= 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("sent %0d requests, checked %0d results", sent, result_total);
        $display("covered add, remove, dump, unused op, inverted and full cases");
        if (fail_count == 0 && pending_count == 0)
            $display("range_set_union_difference regression: pass");
        else
            $display("range_set_union_difference regression: fail");
        $finish;
    end
endmodule
